### rtl/core/bpaf_pkg.sv
package bpaf_pkg;

	localparam int unsigned CAP_DEPTH = 18;

	localparam logic [4:0] MIN_LEN    = 5'd12;
	localparam logic [4:0] PRESET_LEN = 5'd18;
	localparam logic [4:0] COUNT_MAX  = 5'd31;

	localparam logic [7:0] ID_BYTE0 = 8'hFF;
	localparam logic [7:0] ID_BYTE1 = 8'hFF;
	localparam logic [7:0] ID_BYTE2 = 8'h56; // 'V'
	localparam logic [7:0] ID_BYTE3 = 8'h52; // 'R'

	localparam logic [3:0] PRESET_TYPE  = 4'h1;
	localparam logic [7:0] LEGACY_TYPE1 = 8'd1;
	localparam logic [7:0] LEGACY_TYPE2 = 8'd2;
	localparam int unsigned GLOBAL_BIT  = 7;

	localparam logic [15:0] PREV_SEQ_RESET = 16'hFFFF;

	// configuration reset values
	localparam logic        ACCEPT_GLOBAL_RESET  = 1'b0;
	localparam logic [31:0] LEARN_TICKS_RESET    = 32'd10000;
	localparam logic        INIT_FILTER_EN_RESET = 1'b0;
	localparam logic [47:0] INIT_GROUP_KEY_RESET = 48'd0;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_LEARN = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ACCEPT_GLOBAL  = 2'd0,
		REG_LEARN_TICKS    = 2'd1,
		REG_INIT_FILTER_EN = 2'd2,
		REG_INIT_GROUP_KEY = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_SHORT     = 3'd1,
		ST_ID_BAD    = 3'd2,
		ST_TYPE_BAD  = 3'd3,
		ST_GROUP_BAD = 3'd4,
		ST_DUPLICATE = 3'd5,
		ST_GLOBAL    = 3'd6,
		ST_UNUSED    = 3'd7
	} status_t;

	typedef logic [CAP_DEPTH-1:0][7:0] cap_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  effect;
		logic [31:0] timebase;
		logic [47:0] group_key;
		logic        learned;
		logic        legacy_format;
	} result_t;

	// filter and repeat state seen by the packet judge
	typedef struct packed {
		logic [15:0] prev_sequence;
		logic [47:0] prev_group;
		logic [7:0]  prev_kind;
		logic        filter_on;
		logic [47:0] filter_key;
		logic        learn_active;
		logic        accept_global;
	} judge_state_t;

	// state changes requested by the packet judge
	typedef struct packed {
		logic        load_prev;
		logic [15:0] sequence_val;
		logic [47:0] group;
		logic [7:0]  kind;
		logic        learn_hit;
	} judge_upd_t;

endpackage

### rtl/core/ble_preset_advert_filter.sv
// An input transfer lands in the input register when it is accepted; its result, if
// any, then loads the result register and transfers from there once the consumer
// accepts it.
// Throughput: one transfer per cycle; the input register and the result register
// are the only stages, and the input stalls only while a result waits unaccepted.
// Reset (arst_n low): counters, learn window and repeat state clear, configuration
// returns to its defaults, and the filter enable and key load from those defaults.
module ble_preset_advert_filter
	import bpaf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,

	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	// configuration registers; the initial filter values act only on the filter state
	logic        accept_global_q;
	logic [31:0] learn_ticks_q;

	// block state
	logic [4:0]  byte_count_q;
	cap_t        cap_q;
	logic [15:0] prev_sequence_q;
	logic [47:0] prev_group_q;
	logic [7:0]  prev_kind_q;
	logic        filter_on_q;
	logic [47:0] filter_key_q;
	logic        learn_active_q;
	logic [31:0] learn_left_q;

	// input stage
	logic        valid_s1;
	item_t       item_s1;

	// result register
	logic        out_valid_q;
	result_t     out_q;

	logic         is_byte_s1;
	logic         has_result_s1;
	logic         advance_s1;
	logic         fire_s1;
	cap_t         cap_view;
	logic [4:0]   len_s1;
	judge_state_t jst;
	result_t      jres;
	judge_upd_t   jupd;
	logic [31:0]  left_dec;
	logic         cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// The stage moves on when its item yields no result or the result register
	// is free or being drained this cycle.
	assign is_byte_s1    = item_s1.cmd == CMD_BYTE;
	assign has_result_s1 = is_byte_s1 && item_s1.last_byte;
	assign advance_s1    = !has_result_s1 || !out_valid_q || result_ready;
	assign fire_s1       = valid_s1 && advance_s1;
	assign item_ready    = !valid_s1 || advance_s1;

	// Merge the incoming byte into the capture so the judge sees the whole packet.
	always_comb begin
		for (int i = 0; i < CAP_DEPTH; i++) begin
			cap_view[i] = (byte_count_q == 5'(i)) ? item_s1.data_byte : cap_q[i];
		end
	end

	assign len_s1 = (byte_count_q < COUNT_MAX) ? byte_count_q + 5'd1 : COUNT_MAX;

	assign jst.prev_sequence = prev_sequence_q;
	assign jst.prev_group    = prev_group_q;
	assign jst.prev_kind     = prev_kind_q;
	assign jst.filter_on     = filter_on_q;
	assign jst.filter_key    = filter_key_q;
	assign jst.learn_active  = learn_active_q;
	assign jst.accept_global = accept_global_q;

	bpaf_judge u_judge (
		.cap (cap_view),
		.len (len_s1),
		.st  (jst),
		.res (jres),
		.upd (jupd)
	);

	// Tick countdown: step toward zero, never below.
	assign left_dec = (learn_left_q != 32'd0) ? learn_left_q - 32'd1 : 32'd0;

	// Input register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Capture store: written only at the running byte position, no reset.
	always_ff @(posedge clk) begin
		if (fire_s1 && is_byte_s1) begin
			for (int i = 0; i < CAP_DEPTH; i++) begin
				if (byte_count_q == 5'(i)) begin
					cap_q[i] <= item_s1.data_byte;
				end
			end
		end
	end

	// Block state and configuration. Configuration writes come last so a write
	// of the initial filter values takes effect like a reset would.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_global_q  <= ACCEPT_GLOBAL_RESET;
			learn_ticks_q    <= LEARN_TICKS_RESET;
			byte_count_q     <= 5'd0;
			prev_sequence_q  <= PREV_SEQ_RESET;
			prev_group_q     <= 48'd0;
			prev_kind_q      <= 8'd0;
			filter_on_q      <= INIT_FILTER_EN_RESET;
			filter_key_q     <= INIT_GROUP_KEY_RESET;
			learn_active_q   <= 1'b0;
			learn_left_q     <= 32'd0;
		end else begin
			if (fire_s1) begin
				case (item_s1.cmd)
					CMD_LEARN: begin
						// open the window unless learning is disabled
						if (learn_ticks_q != 32'd0) begin
							learn_active_q <= 1'b1;
							learn_left_q   <= learn_ticks_q;
						end
					end
					CMD_TICK: begin
						if (learn_active_q && learn_ticks_q != 32'd0) begin
							learn_left_q <= left_dec;
							if (left_dec == 32'd0) begin
								learn_active_q <= 1'b0;
							end
						end
					end
					CMD_BYTE: begin
						if (item_s1.last_byte) begin
							byte_count_q <= 5'd0;
							if (jupd.load_prev) begin
								prev_sequence_q <= jupd.sequence_val;
								prev_group_q    <= jupd.group;
								prev_kind_q     <= jupd.kind;
							end
							if (jupd.learn_hit) begin
								learn_active_q <= 1'b0;
								learn_left_q   <= 32'd0;
								filter_on_q    <= 1'b1;
								filter_key_q   <= jupd.group;
							end
						end else begin
							byte_count_q <= len_s1;
						end
					end
					default: begin
						// unused command: drop
					end
				endcase
			end
			if (cfg_fire) begin
				case (cfg_index)
					REG_ACCEPT_GLOBAL: accept_global_q <= cfg_data[0];
					REG_LEARN_TICKS:   learn_ticks_q   <= cfg_data[31:0];
					REG_INIT_FILTER_EN: begin
						filter_on_q <= cfg_data[0];
					end
					REG_INIT_GROUP_KEY: begin
						filter_key_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result register: hold until the consumer takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && has_result_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_result_s1) begin
			out_q <= jres;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### rtl/core/bpaf_judge.sv
module bpaf_judge
	import bpaf_pkg::*;
(
	input  cap_t         cap,
	input  logic [4:0]   len,
	input  judge_state_t st,
	output result_t      res,
	output judge_upd_t   upd
);

	logic        is_short;
	logic        is_preset;
	logic        ids_ok;
	logic [7:0]  kind;
	logic [15:0] seq;
	logic [47:0] key;

	assign is_short  = len < MIN_LEN;
	assign is_preset = len >= PRESET_LEN;
	assign kind      = cap[4];
	assign seq       = {cap[6], cap[5]};
	assign key       = is_preset ? {cap[12], cap[13], cap[14], cap[15], cap[16], cap[17]}
	                             : 48'd0;
	assign ids_ok    = (cap[0] == ID_BYTE0) && (cap[1] == ID_BYTE1) &&
	                   (cap[2] == ID_BYTE2) && (cap[3] == ID_BYTE3);

	always_comb begin
		res.status        = ST_ACCEPTED;
		res.effect        = cap[7];
		res.timebase      = {cap[11], cap[10], cap[9], cap[8]};
		res.group_key     = key;
		res.learned       = 1'b0;
		res.legacy_format = !is_preset;
		upd.load_prev     = 1'b0;
		upd.sequence_val  = seq;
		upd.group         = key;
		upd.kind          = kind;
		upd.learn_hit     = 1'b0;

		if (is_short) begin
			res = '0;
			res.status = ST_SHORT;
		end else if (!ids_ok) begin
			res.status = ST_ID_BAD;
		end else if (is_preset) begin
			if (kind[3:0] != PRESET_TYPE) begin
				res.status = ST_TYPE_BAD;
			end else if (!st.learn_active && st.filter_on && key != st.filter_key) begin
				res.status = ST_GROUP_BAD;
			end else if (seq == st.prev_sequence && key == st.prev_group &&
			             kind == st.prev_kind) begin
				res.status = ST_DUPLICATE;
			end else begin
				upd.load_prev = 1'b1;
				// learn the first nonzero key while the window is open
				if (st.learn_active && key != 48'd0) begin
					upd.learn_hit = 1'b1;
					res.learned   = 1'b1;
				end
				if (!st.learn_active && kind[GLOBAL_BIT] && !st.accept_global) begin
					res.status = ST_GLOBAL;
				end
			end
		end else begin
			if (kind != LEGACY_TYPE1 && kind != LEGACY_TYPE2) begin
				res.status = ST_TYPE_BAD;
			end else if (seq == st.prev_sequence && kind == st.prev_kind) begin
				res.status = ST_DUPLICATE;
			end else begin
				upd.load_prev = 1'b1;
			end
		end
	end

endmodule
